### rtl/core/eatb_pkg.sv
// eatb_pkg: constants, types and helpers of the edge arrowhead triangle builder.
// Used by eatb_mul, eatb_cordic and edge_arrowhead_triangle_builder.
// No dependencies.
package eatb_pkg;

	localparam int PATH_POINTS   = 4;
	localparam int COORD_BITS    = 15;
	localparam int FRAC_BITS     = 8;
	localparam int CORDIC_STAGES = 16;

	localparam int SIZE_W    = 12;
	localparam int SIZE_FRAC = 8;
	localparam int SCALE_W   = 16;
	localparam int GUARD     = 8;
	localparam int COLOR_W   = 24;
	localparam int OUT_W     = 24;
	localparam int OUT_MAX   = 8388607;
	localparam int OUT_MIN   = -8388608;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd2560;

	localparam int IDX_W  = $clog2(PATH_POINTS);
	localparam int LAST   = PATH_POINTS - 1;
	localparam int SCNT_W = $clog2(CORDIC_STAGES);

	// vector path: delta << stages, plus growth and prerotation headroom
	localparam int UW = COORD_BITS + 1 + CORDIC_STAGES + 3;
	localparam int WW = 32;            // offset path
	localparam int MA_W = 32;
	localparam int MB_W = 25;
	localparam int MP_W = MA_W + MB_W;
	localparam int KINV_W = 24;
	localparam logic [KINV_W-1:0] KINV = 24'd10188014;   // 1/K in Q24
	localparam int RSH = KINV_W + GUARD;                  // final rounding shift
	localparam int RW  = 26;                              // rotated offset
	localparam int SUM_W = 27;
	localparam int THR_W = 2 * SIZE_W - 2 * SIZE_FRAC;
	localparam int PSH   = 2 * SIZE_FRAC - FRAC_BITS;
	localparam int PIX_W = SIZE_W + SCALE_W - PSH + 1;
	localparam int D2_W  = 2 * COORD_BITS;

	localparam logic [1:0] DIR_FWD  = 2'd0;
	localparam logic [1:0] DIR_BACK = 2'd1;
	localparam logic [1:0] DIR_BOTH = 2'd2;
	localparam logic [1:0] DIR_NONE = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE, ST_THR, ST_PIX, ST_SIZE, ST_ARROW, ST_RD, ST_DX, ST_DY, ST_CMP,
		ST_ROT, ST_CORD, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_OUT
	} st_t;

	typedef struct packed {
		logic signed [UW-1:0] cx;
		logic signed [UW-1:0] cy;
		logic signed [WW-1:0] w1x;
		logic signed [WW-1:0] w1y;
		logic signed [WW-1:0] w2x;
		logic signed [WW-1:0] w2y;
	} cord_in_t;

	typedef struct packed {
		logic signed [WW-1:0] w1x;
		logic signed [WW-1:0] w1y;
		logic signed [WW-1:0] w2x;
		logic signed [WW-1:0] w2y;
	} cord_out_t;

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > SUM_W'(OUT_MAX)) begin
			r = OUT_W'(OUT_MAX);
		end else if (v < SUM_W'(OUT_MIN)) begin
			r = OUT_W'(OUT_MIN);
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/eatb_mul.sv
// eatb_mul: shared signed multiplier with a registered product.
// Depends on eatb_pkg.
module eatb_mul (
	input  logic                              clk,
	input  logic signed [eatb_pkg::MA_W-1:0]  a,
	input  logic signed [eatb_pkg::MB_W-1:0]  b,
	output logic signed [eatb_pkg::MP_W-1:0]  p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

### rtl/core/eatb_cordic.sv
// eatb_cordic: vectoring CORDIC, one micro-rotation per cycle, replayed on two offsets.
// Depends on eatb_pkg.
module eatb_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  eatb_pkg::cord_in_t    din,
	output logic                  busy,
	output logic                  done,
	output eatb_pkg::cord_out_t   dout
);

	logic signed [eatb_pkg::UW-1:0] cx_q, cy_q;
	logic signed [eatb_pkg::WW-1:0] w1x_q, w1y_q, w2x_q, w2y_q;
	logic [eatb_pkg::SCNT_W-1:0]    cnt_q;
	logic                           busy_q;

	logic signed [eatb_pkg::UW-1:0] sx, sy;
	logic signed [eatb_pkg::WW-1:0] q1x, q1y, q2x, q2y;
	logic                           pos;

	assign sx  = cx_q >>> cnt_q;
	assign sy  = cy_q >>> cnt_q;
	assign q1x = w1x_q >>> cnt_q;
	assign q1y = w1y_q >>> cnt_q;
	assign q2x = w2x_q >>> cnt_q;
	assign q2y = w2y_q >>> cnt_q;
	assign pos = !cy_q[eatb_pkg::UW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == eatb_pkg::SCNT_W'(eatb_pkg::CORDIC_STAGES - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (din.cx[eatb_pkg::UW-1]) begin
				// quarter turn into the right half plane
				if (!din.cy[eatb_pkg::UW-1]) begin
					cx_q  <= din.cy;   cy_q  <= -din.cx;
					w1x_q <= din.w1y;  w1y_q <= -din.w1x;
					w2x_q <= din.w2y;  w2y_q <= -din.w2x;
				end else begin
					cx_q  <= -din.cy;  cy_q  <= din.cx;
					w1x_q <= -din.w1y; w1y_q <= din.w1x;
					w2x_q <= -din.w2y; w2y_q <= din.w2x;
				end
			end else begin
				cx_q  <= din.cx;  cy_q  <= din.cy;
				w1x_q <= din.w1x; w1y_q <= din.w1y;
				w2x_q <= din.w2x; w2y_q <= din.w2y;
			end
		end else if (busy_q) begin
			if (pos) begin
				cx_q  <= cx_q + sy;   cy_q  <= cy_q - sx;
				w1x_q <= w1x_q + q1y; w1y_q <= w1y_q - q1x;
				w2x_q <= w2x_q + q2y; w2y_q <= w2y_q - q2x;
			end else begin
				cx_q  <= cx_q - sy;   cy_q  <= cy_q + sx;
				w1x_q <= w1x_q - q1y; w1y_q <= w1y_q + q1x;
				w2x_q <= w2x_q - q2y; w2y_q <= w2y_q + q2x;
			end
		end
	end

	assign busy = busy_q;
	assign done = busy_q && (cnt_q == eatb_pkg::SCNT_W'(eatb_pkg::CORDIC_STAGES - 1));
	assign dout = '{w1x: w1x_q, w1y: w1y_q, w2x: w2x_q, w2y: w2y_q};

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !done |=> busy_q)
		else $error("cordic stopped early");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done && !start |=> !busy_q)
		else $error("cordic ran past last stage");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("cordic started while busy");

endmodule

### rtl/core/edge_arrowhead_triangle_builder.sv
// edge_arrowhead_triangle_builder: top level, point store, sequencer and output register.
// Depends on eatb_pkg, eatb_mul, eatb_cordic.
//
//  channel | handshake                     | beat
//  --------+-------------------------------+------------------------------------------
//  in      | in_valid / in_stall (out)     | one path point plus edge fields
//  out     | out_valid / out_stall (in)    | one arrowhead triangle
//  apb     | psel penable pwrite pready    | pixel scale register at byte addresses 0 to 3
//
// A point beat that is not last only stores the point and leaves the sequencer idle. A last
// beat with arrows runs the setup steps THR, PIX and SIZE, then per arrow ARROW, a search of
// RD, DX, DY and CMP for each point tested on the shared multiplier, ROT, the CORDIC run in
// CORD, 1/K scaling in M0 to M4 and the output step OUT; coincident points skip the CORDIC
// and scaling steps. in_stall is high until the final triangle is registered, and an output stall holds OUT.
// Reset clears control state and sets the pixel scale to 10.0; the point store is not cleared.
module edge_arrowhead_triangle_builder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// APB configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [2:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	// input beat
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [eatb_pkg::COORD_BITS-1:0]       point_x,
	input  logic [eatb_pkg::COORD_BITS-1:0]       point_y,
	input  logic                                  last_point,
	input  logic [eatb_pkg::SIZE_W-1:0]           tri_size,
	input  logic [1:0]                            dir_code,
	input  logic                                  dest_above,
	input  logic                                  head_none,
	input  logic                                  tail_none,
	input  logic                                  src_ghost,
	input  logic                                  dest_ghost,
	input  logic [eatb_pkg::COLOR_W-1:0]          rgb_in,
	// output beat
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [eatb_pkg::OUT_W-1:0]     tip_x,
	output logic signed [eatb_pkg::OUT_W-1:0]     tip_y,
	output logic signed [eatb_pkg::OUT_W-1:0]     left_x,
	output logic signed [eatb_pkg::OUT_W-1:0]     left_y,
	output logic signed [eatb_pkg::OUT_W-1:0]     right_x,
	output logic signed [eatb_pkg::OUT_W-1:0]     right_y,
	output logic                                  arrow_up,
	output logic [eatb_pkg::COLOR_W-1:0]          color_out,
	output logic                                  last_of_run
);

	localparam int CW = eatb_pkg::COORD_BITS;

	eatb_pkg::st_t state_q, state_d;

	// configuration
	logic [eatb_pkg::SCALE_W-1:0] scale_q;
	logic                         cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {{(32 - eatb_pkg::SCALE_W){1'b0}}, scale_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= eatb_pkg::SCALE_RESET;
		end else if (cfg_wr) begin
			scale_q <= pwdata[eatb_pkg::SCALE_W-1:0];
		end
	end

	// point store: written at one address, read at idx_q through a register
	logic [CW-1:0] mem_x [eatb_pkg::PATH_POINTS];
	logic [CW-1:0] mem_y [eatb_pkg::PATH_POINTS];
	logic [CW-1:0] rd_x_q, rd_y_q;
	logic [eatb_pkg::IDX_W-1:0] cnt_q, idx_q;

	logic in_acc, out_acc;
	assign in_stall = (state_q != eatb_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (last_point) begin
				mem_x[eatb_pkg::LAST] <= point_x;
				mem_y[eatb_pkg::LAST] <= point_y;
			end else if (cnt_q < eatb_pkg::IDX_W'(eatb_pkg::LAST)) begin
				mem_x[cnt_q] <= point_x;
				mem_y[cnt_q] <= point_y;
			end
		end
		rd_x_q <= mem_x[idx_q];
		rd_y_q <= mem_y[idx_q];
	end

	// arrow selection on the last beat
	logic up_ghost, dn_ghost, up_none, dn_none, sel_up, sel_dn;
	always_comb begin
		up_ghost = dest_above ? dest_ghost : src_ghost;
		dn_ghost = dest_above ? src_ghost : dest_ghost;
		up_none  = dest_above ? head_none : tail_none;
		dn_none  = dest_above ? tail_none : head_none;
		sel_up = (dir_code == eatb_pkg::DIR_BOTH) ||
			(dir_code == eatb_pkg::DIR_FWD && dest_above) ||
			(dir_code == eatb_pkg::DIR_BACK && !dest_above);
		sel_dn = (dir_code == eatb_pkg::DIR_BOTH) ||
			(dir_code == eatb_pkg::DIR_FWD && !dest_above) ||
			(dir_code == eatb_pkg::DIR_BACK && dest_above);
		sel_up = sel_up && !up_ghost && !up_none;
		sel_dn = sel_dn && !dn_ghost && !dn_none;
	end

	// edge and arrow registers
	logic [eatb_pkg::SIZE_W-1:0]  asize_q;
	logic [eatb_pkg::COLOR_W-1:0] color_q;
	logic                         has_up_q, has_dn_q, up_q, front_q, rot_q;
	logic [eatb_pkg::THR_W-1:0]   thr_q;
	logic [eatb_pkg::PIX_W-1:0]   pix_q, half_q;
	logic [CW-1:0]                ax_q, ay_q, bx_q, by_q;
	logic [eatb_pkg::D2_W-1:0]    sq_q;
	logic signed [eatb_pkg::RW-1:0] r1x_q, r1y_q, r2x_q, r2y_q;

	// shared multiplier
	logic signed [eatb_pkg::MA_W-1:0] ma;
	logic signed [eatb_pkg::MB_W-1:0] mb;
	logic signed [eatb_pkg::MP_W-1:0] mp;

	eatb_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_q(mp));

	// CORDIC unit
	logic                  cord_start, cord_busy, cord_done;
	eatb_pkg::cord_in_t    cord_in;
	eatb_pkg::cord_out_t   cord_out;

	eatb_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start), .din(cord_in),
		.busy(cord_busy), .done(cord_done), .dout(cord_out)
	);

	// datapath helpers
	logic signed [CW:0]                dx, dy, ux, uy;
	logic [eatb_pkg::D2_W:0]           d2;
	logic                              hit, walk_end, front_lt, use_front, pend;
	logic [eatb_pkg::SIZE_W+eatb_pkg::SCALE_W:0] prod_r;
	logic signed [eatb_pkg::WW-1:0]    hw, ow;
	logic signed [eatb_pkg::RW-1:0]    half_s, oy_s, mrnd;
	logic signed [eatb_pkg::MP_W-1:0]  mp_r;

	assign dx = $signed({1'b0, ax_q}) - $signed({1'b0, rd_x_q});
	assign dy = $signed({1'b0, ay_q}) - $signed({1'b0, rd_y_q});
	assign ux = $signed({1'b0, ax_q}) - $signed({1'b0, bx_q});
	assign uy = $signed({1'b0, by_q}) - $signed({1'b0, ay_q});
	assign d2 = {1'b0, sq_q} + {1'b0, mp[eatb_pkg::D2_W-1:0]};
	assign hit = d2 > (eatb_pkg::D2_W + 1)'(thr_q);
	assign walk_end = front_q ? (idx_q == eatb_pkg::IDX_W'(eatb_pkg::LAST))
		: (idx_q == '0);
	assign front_lt  = mem_y[0] < mem_y[eatb_pkg::LAST];
	assign use_front = up_q ? front_lt : !front_lt;
	assign pend = up_q && has_dn_q;

	assign prod_r = {1'b0, mp[eatb_pkg::SIZE_W+eatb_pkg::SCALE_W-1:0]};
	assign half_s = eatb_pkg::RW'($signed({1'b0, half_q}));
	assign oy_s   = up_q ? eatb_pkg::RW'($signed({1'b0, pix_q}))
		: -eatb_pkg::RW'($signed({1'b0, pix_q}));
	assign hw = eatb_pkg::WW'($signed({1'b0, half_q})) <<< eatb_pkg::GUARD;
	assign ow = eatb_pkg::WW'(oy_s) <<< eatb_pkg::GUARD;
	// round half up of product * 1/K
	assign mp_r = mp + (eatb_pkg::MP_W'(1) <<< (eatb_pkg::RSH - 1));
	assign mrnd = eatb_pkg::RW'($signed(mp_r[eatb_pkg::MP_W-1:eatb_pkg::RSH]));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			eatb_pkg::ST_IDLE:  if (in_acc && last_point && (sel_up || sel_dn)) begin
				state_d = eatb_pkg::ST_THR;
			end
			eatb_pkg::ST_THR:   state_d = eatb_pkg::ST_PIX;
			eatb_pkg::ST_PIX:   state_d = eatb_pkg::ST_SIZE;
			eatb_pkg::ST_SIZE:  state_d = eatb_pkg::ST_ARROW;
			eatb_pkg::ST_ARROW: state_d = eatb_pkg::ST_RD;
			eatb_pkg::ST_RD:    state_d = eatb_pkg::ST_DX;
			eatb_pkg::ST_DX:    state_d = eatb_pkg::ST_DY;
			eatb_pkg::ST_DY:    state_d = eatb_pkg::ST_CMP;
			eatb_pkg::ST_CMP:   state_d = (hit || walk_end) ? eatb_pkg::ST_ROT : eatb_pkg::ST_RD;
			eatb_pkg::ST_ROT:   state_d = (ux != '0 || uy != '0) ? eatb_pkg::ST_CORD
				: eatb_pkg::ST_OUT;
			eatb_pkg::ST_CORD:  if (cord_done) begin
				state_d = eatb_pkg::ST_M0;
			end
			eatb_pkg::ST_M0:    state_d = eatb_pkg::ST_M1;
			eatb_pkg::ST_M1:    state_d = eatb_pkg::ST_M2;
			eatb_pkg::ST_M2:    state_d = eatb_pkg::ST_M3;
			eatb_pkg::ST_M3:    state_d = eatb_pkg::ST_M4;
			eatb_pkg::ST_M4:    state_d = eatb_pkg::ST_OUT;
			eatb_pkg::ST_OUT:   if (!out_valid || !out_stall) begin
				state_d = pend ? eatb_pkg::ST_ARROW : eatb_pkg::ST_IDLE;
			end
			default:            state_d = eatb_pkg::ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		ma = '0;
		mb = '0;
		cord_start = 1'b0;
		cord_in = '{cx: eatb_pkg::UW'(ux) <<< eatb_pkg::CORDIC_STAGES,
			cy: eatb_pkg::UW'(uy) <<< eatb_pkg::CORDIC_STAGES,
			w1x: -hw, w1y: ow, w2x: hw, w2y: ow};
		case (state_q)
			eatb_pkg::ST_THR: begin
				ma = eatb_pkg::MA_W'({1'b0, asize_q});
				mb = eatb_pkg::MB_W'({1'b0, asize_q});
			end
			eatb_pkg::ST_PIX: begin
				ma = eatb_pkg::MA_W'({1'b0, scale_q});
				mb = eatb_pkg::MB_W'({1'b0, asize_q});
			end
			eatb_pkg::ST_DX: begin
				ma = eatb_pkg::MA_W'(dx);
				mb = eatb_pkg::MB_W'(dx);
			end
			eatb_pkg::ST_DY: begin
				ma = eatb_pkg::MA_W'(dy);
				mb = eatb_pkg::MB_W'(dy);
			end
			eatb_pkg::ST_ROT: cord_start = (ux != '0 || uy != '0);
			eatb_pkg::ST_M0: begin
				ma = cord_out.w1x;
				mb = eatb_pkg::MB_W'({1'b0, eatb_pkg::KINV});
			end
			eatb_pkg::ST_M1: begin
				ma = cord_out.w1y;
				mb = eatb_pkg::MB_W'({1'b0, eatb_pkg::KINV});
			end
			eatb_pkg::ST_M2: begin
				ma = cord_out.w2x;
				mb = eatb_pkg::MB_W'({1'b0, eatb_pkg::KINV});
			end
			eatb_pkg::ST_M3: begin
				ma = cord_out.w2y;
				mb = eatb_pkg::MB_W'({1'b0, eatb_pkg::KINV});
			end
			default: begin
				ma = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= eatb_pkg::ST_IDLE;
			cnt_q    <= '0;
			has_up_q <= 1'b0;
			has_dn_q <= 1'b0;
			up_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				if (last_point) begin
					cnt_q    <= '0;
					has_up_q <= sel_up;
					has_dn_q <= sel_dn;
				end else if (cnt_q < eatb_pkg::IDX_W'(eatb_pkg::LAST)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (state_q == eatb_pkg::ST_SIZE) begin
				up_q <= has_up_q;
			end else if (state_q == eatb_pkg::ST_OUT && state_d == eatb_pkg::ST_ARROW) begin
				up_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc && last_point) begin
			asize_q <= tri_size;
			color_q <= rgb_in;
		end
		case (state_q)
			eatb_pkg::ST_PIX:  thr_q <= mp[2*eatb_pkg::SIZE_FRAC +: eatb_pkg::THR_W];
			eatb_pkg::ST_SIZE: begin
				pix_q  <= eatb_pkg::PIX_W'((prod_r + (eatb_pkg::PIX_W+eatb_pkg::PSH)'(
					1 << (eatb_pkg::PSH - 1))) >> eatb_pkg::PSH);
				half_q <= eatb_pkg::PIX_W'((prod_r + (eatb_pkg::PIX_W+eatb_pkg::PSH)'(
					1 << eatb_pkg::PSH)) >> (eatb_pkg::PSH + 1));
			end
			eatb_pkg::ST_ARROW: begin
				front_q <= use_front;
				ax_q    <= use_front ? mem_x[0] : mem_x[eatb_pkg::LAST];
				ay_q    <= use_front ? mem_y[0] : mem_y[eatb_pkg::LAST];
				idx_q   <= use_front ? eatb_pkg::IDX_W'(1) : eatb_pkg::IDX_W'(eatb_pkg::LAST - 1);
			end
			eatb_pkg::ST_DY:  sq_q <= mp[eatb_pkg::D2_W-1:0];
			eatb_pkg::ST_CMP: begin
				if (hit || walk_end) begin
					bx_q <= rd_x_q;
					by_q <= rd_y_q;
				end else if (front_q) begin
					idx_q <= idx_q + 1'b1;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
			eatb_pkg::ST_ROT: begin
				rot_q <= (ux != '0 || uy != '0);
				// coincident points: offsets pass unrotated
				r1x_q <= -half_s;
				r1y_q <= oy_s;
				r2x_q <= half_s;
				r2y_q <= oy_s;
			end
			eatb_pkg::ST_M1: r1x_q <= mrnd;
			eatb_pkg::ST_M2: r1y_q <= mrnd;
			eatb_pkg::ST_M3: r2x_q <= mrnd;
			eatb_pkg::ST_M4: r2y_q <= mrnd;
			default: begin
			end
		endcase
	end

	// vertex assembly: offset turned by +i (up) or -i (down), added to the tip
	logic signed [eatb_pkg::SUM_W-1:0] tx, ty, v1x, v1y, v2x, v2y;
	logic signed [eatb_pkg::SUM_W-1:0] e1x, e1y, e2x, e2y;
	logic out_load;

	always_comb begin
		tx = eatb_pkg::SUM_W'({1'b0, ax_q, {eatb_pkg::FRAC_BITS{1'b0}}})
			+ eatb_pkg::SUM_W'(1 << (eatb_pkg::FRAC_BITS - 1));
		ty = eatb_pkg::SUM_W'({1'b0, ay_q, {eatb_pkg::FRAC_BITS{1'b0}}});
		e1x = eatb_pkg::SUM_W'(r1x_q);
		e1y = eatb_pkg::SUM_W'(r1y_q);
		e2x = eatb_pkg::SUM_W'(r2x_q);
		e2y = eatb_pkg::SUM_W'(r2y_q);
		v1x = up_q ? tx - e1y : tx + e1y;
		v1y = up_q ? ty + e1x : ty - e1x;
		v2x = up_q ? tx - e2y : tx + e2y;
		v2y = up_q ? ty + e2x : ty - e2x;
	end

	assign out_load = (state_q == eatb_pkg::ST_OUT) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_acc) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			tip_x       <= eatb_pkg::sat_out(tx);
			tip_y       <= eatb_pkg::sat_out(ty);
			left_x      <= eatb_pkg::sat_out(v1x);
			left_y      <= eatb_pkg::sat_out(v1y);
			right_x     <= eatb_pkg::sat_out(v2x);
			right_y     <= eatb_pkg::sat_out(v2y);
			arrow_up    <= up_q;
			color_out   <= color_q;
			last_of_run <= !pend;
		end
	end

	a_cord_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cord_busy |-> state_q == eatb_pkg::ST_CORD)
		else $error("cordic busy outside its step");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= eatb_pkg::IDX_W'(eatb_pkg::LAST))
		else $error("point count overrun");
	a_mid_point: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !last_point |=> state_q == eatb_pkg::ST_IDLE)
		else $error("middle point started work");
	a_rot_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == eatb_pkg::ST_M0 |-> rot_q)
		else $error("scaling pass without rotation");

endmodule

### test/edge_arrowhead_triangle_builder_tb.sv
// Self-checking testbench for edge_arrowhead_triangle_builder: point beats in, arrowhead
// triangles out, pixel scale written over APB between phases. Depends on eatb_pkg and the RTL.
module edge_arrowhead_triangle_builder_tb;

	typedef struct {
		logic [14:0] px;
		logic [14:0] py;
		logic        last;
		logic [11:0] asize;
		logic [1:0]  dir;
		logic        above;
		logic        hnone;
		logic        tnone;
		logic        sghost;
		logic        dghost;
		logic [23:0] color;
	} beat_t;

	typedef struct {
		logic signed [23:0] v [6];
		logic               up;
		logic [23:0]        color;
		logic               last;
	} tri_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic in_valid = 0, in_stall;
	logic [14:0] point_x = '0, point_y = '0;
	logic last_point = 0;
	logic [11:0] tri_size = '0;
	logic [1:0] dir_code = eatb_pkg::DIR_FWD;
	logic dest_above = 0, head_none = 0, tail_none = 0, src_ghost = 0, dest_ghost = 0;
	logic [23:0] rgb_in = '0;
	logic out_valid, out_stall = 0;
	logic signed [23:0] tip_x, tip_y, left_x, left_y, right_x, right_y;
	logic arrow_up, last_of_run;
	logic [23:0] color_out;

	edge_arrowhead_triangle_builder dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// pending point beats, expected triangles, predictor state
	beat_t beat_q[$];
	tri_t  tri_q[$];
	logic [14:0] path_x [4];
	logic [14:0] path_y [4];
	int held_cnt = 0;
	bit store_loaded = 0;
	logic [15:0] scale_now = eatb_pkg::SCALE_RESET;
	bit no_idle = 0;
	int beats_sent = 0, tris_seen = 0, mismatches = 0, edges_sent = 0;
	longint cycles = 0;

	function automatic logic signed [23:0] clamp24(longint v);
		if (v > eatb_pkg::OUT_MAX) return 24'(eatb_pkg::OUT_MAX);
		if (v < eatb_pkg::OUT_MIN) return 24'(eatb_pkg::OUT_MIN);
		return v[23:0];
	endfunction

	// one triangle: far-point walk, offsets, CORDIC replay, 1/K scaling
	function automatic tri_t build_arrow(bit up, logic [11:0] asz, logic [23:0] col);
		tri_t t;
		bit use_front, turn;
		int ai, bi, i, st, s, v;
		longint dx, dy, thr, prod, pix, half, tx, ty, oy, ux, uy;
		longint cx, cy, wx, wy, sx, sy, qx, qy, tmp, rx, ry, fx, fy;
		use_front = up ? (path_y[0] < path_y[3]) : !(path_y[0] < path_y[3]);
		ai = use_front ? 0 : 3;
		bi = use_front ? 3 : 0;
		st = use_front ? 1 : -1;
		thr = (longint'(asz) * asz) >> 16;
		for (i = ai + st; i >= 0 && i < 4; i += st) begin
			dx = longint'(path_x[ai]) - path_x[i];
			dy = longint'(path_y[ai]) - path_y[i];
			if (dx * dx + dy * dy > thr) begin
				bi = i;
				break;
			end
		end
		prod = longint'(asz) * scale_now;
		pix = (prod + 128) >> 8;
		half = (prod + 256) >> 9;
		tx = (longint'(path_x[ai]) << 8) + 128;
		ty = longint'(path_y[ai]) << 8;
		oy = up ? pix : -pix;
		ux = longint'(path_x[ai]) - path_x[bi];
		uy = longint'(path_y[bi]) - path_y[ai];
		turn = (ux != 0 || uy != 0);
		ux = ux * 65536;
		uy = uy * 65536;
		for (v = 0; v < 2; v++) begin
			wx = (v == 0 ? -half : half) * 256;
			wy = oy * 256;
			if (turn) begin
				cx = ux;
				cy = uy;
				// quarter-turn prerotation for the left half plane
				if (cx < 0) begin
					if (cy >= 0) begin
						tmp = cx; cx = cy; cy = -tmp;
						tmp = wx; wx = wy; wy = -tmp;
					end else begin
						tmp = cx; cx = -cy; cy = tmp;
						tmp = wx; wx = -wy; wy = tmp;
					end
				end
				for (s = 0; s < 16; s++) begin
					sx = cx >>> s; sy = cy >>> s;
					qx = wx >>> s; qy = wy >>> s;
					if (cy >= 0) begin
						cx += sy; cy -= sx; wx += qy; wy -= qx;
					end else begin
						cx -= sy; cy += sx; wx -= qy; wy += qx;
					end
				end
				rx = (wx * 10188014 + (longint'(1) << 31)) >>> 32;
				ry = (wy * 10188014 + (longint'(1) << 31)) >>> 32;
			end else begin
				rx = wx >>> 8;
				ry = wy >>> 8;
			end
			fx = up ? -ry : ry;
			fy = up ? rx : -rx;
			t.v[2 + 2 * v] = clamp24(tx + fx);
			t.v[3 + 2 * v] = clamp24(ty + fy);
		end
		t.v[0] = clamp24(tx);
		t.v[1] = clamp24(ty);
		t.up = up;
		t.color = col;
		t.last = 0;
		return t;
	endfunction

	// advance the point store on one beat and queue the triangles it yields
	function automatic void predict_beat(beat_t b);
		bit up_g, dn_g, up_n, dn_n, has_up, has_dn;
		tri_t a;
		if (!b.last) begin
			if (held_cnt < 3) begin
				path_x[held_cnt] = b.px;
				path_y[held_cnt] = b.py;
				held_cnt++;
			end
			return;
		end
		path_x[3] = b.px;
		path_y[3] = b.py;
		held_cnt = 0;
		up_g = b.above ? b.dghost : b.sghost;
		dn_g = b.above ? b.sghost : b.dghost;
		up_n = b.above ? b.hnone : b.tnone;
		dn_n = b.above ? b.tnone : b.hnone;
		has_up = (b.dir == eatb_pkg::DIR_BOTH) || (b.dir == eatb_pkg::DIR_FWD && b.above) ||
			(b.dir == eatb_pkg::DIR_BACK && !b.above);
		has_dn = (b.dir == eatb_pkg::DIR_BOTH) || (b.dir == eatb_pkg::DIR_FWD && !b.above) ||
			(b.dir == eatb_pkg::DIR_BACK && b.above);
		has_up = has_up && !up_g && !up_n;
		has_dn = has_dn && !dn_g && !dn_n;
		if (has_up) begin
			a = build_arrow(1, b.asize, b.color);
			a.last = !has_dn;
			tri_q.push_back(a);
		end
		if (has_dn) begin
			a = build_arrow(0, b.asize, b.color);
			a.last = 1;
			tri_q.push_back(a);
		end
	endfunction

	function automatic beat_t rand_beat(bit last);
		beat_t b;
		b.px = 15'($urandom);
		b.py = 15'($urandom);
		b.last = last;
		b.asize = 12'($urandom);
		b.dir = 2'($urandom);
		b.above = 1'($urandom);
		b.hnone = ($urandom_range(0, 5) == 0);
		b.tnone = ($urandom_range(0, 5) == 0);
		b.sghost = ($urandom_range(0, 5) == 0);
		b.dghost = ($urandom_range(0, 5) == 0);
		b.color = 24'($urandom);
		return b;
	endfunction

	function automatic logic [14:0] near(int base, int spread);
		int c;
		c = base + int'($urandom_range(0, 2 * spread)) - spread;
		if (c < 0) c = 0;
		if (c > 32767) c = 32767;
		return 15'(c);
	endfunction

	function automatic void queue_beat(beat_t b);
		beat_q.push_back(b);
		predict_beat(b);
		if (b.last) begin
			edges_sent++;
			store_loaded = 1;
		end
	endfunction

	// one random path; early last only once every slot has been written
	function automatic void random_edge();
		beat_t b;
		int n, k, bx, by, spread;
		n = 3;
		k = $urandom_range(0, 9);
		if (store_loaded && k == 0) n = $urandom_range(0, 2);
		else if (k == 1) n = $urandom_range(4, 6);
		bx = $urandom_range(0, 32767);
		by = $urandom_range(0, 32767);
		case ($urandom_range(0, 4))
			0: spread = 0;
			1: spread = 4;
			2: spread = 24;
			3: spread = 300;
			default: spread = 20000;
		endcase
		for (int j = 0; j <= n; j++) begin
			b = rand_beat(j == n);
			b.px = near(bx, spread);
			b.py = near(by, spread);
			if ($urandom_range(0, 2) == 0) b.asize = 12'($urandom_range(0, 600));
			queue_beat(b);
		end
	endfunction

	function automatic void directed_edge(int x0, int y0, int x1, int y1, int x2, int y2,
			int x3, int y3, logic [11:0] asz, logic [1:0] dir, bit above);
		beat_t b;
		int xs [4];
		int ys [4];
		xs = '{x0, x1, x2, x3};
		ys = '{y0, y1, y2, y3};
		for (int j = 0; j < 4; j++) begin
			b = rand_beat(j == 3);
			b.px = 15'(xs[j]);
			b.py = 15'(ys[j]);
			b.asize = asz;
			b.dir = dir;
			b.above = above;
			{b.hnone, b.tnone, b.sghost, b.dghost} = '0;
			queue_beat(b);
		end
	endfunction

	// sender: random idle gap between beats unless in a no-idle stretch
	int send_gap = 0;
	always @(posedge clk) begin
		beat_t b;
		bit free;
		cycles++;
		if (arst_n) begin
			free = !in_valid || !in_stall;
			if (in_valid && !in_stall) beats_sent++;
			if (free) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 0;
				end else if (beat_q.size() > 0) begin
					b = beat_q.pop_front();
					point_x <= b.px;
					point_y <= b.py;
					last_point <= b.last;
					tri_size <= b.asize;
					dir_code <= b.dir;
					dest_above <= b.above;
					head_none <= b.hnone;
					tail_none <= b.tnone;
					src_ghost <= b.sghost;
					dest_ghost <= b.dghost;
					rgb_in <= b.color;
					in_valid <= 1;
					send_gap = no_idle ? 0 : $urandom_range(0, 12);
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// receiver: stall drawn after each accepted triangle
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1;
			end else begin
				out_stall <= 0;
				if (out_valid) stall_left = no_idle ? 0 : $urandom_range(0, 12);
			end
		end
	end

	// checker: compare each accepted triangle with the oldest expectation
	always @(posedge clk) begin
		tri_t e;
		logic signed [23:0] got [6];
		bit bad;
		if (arst_n && out_valid && !out_stall) begin
			tris_seen++;
			got = '{tip_x, tip_y, left_x, left_y, right_x, right_y};
			if (tri_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected triangle tip (%0d,%0d)", tip_x, tip_y);
			end else begin
				e = tri_q.pop_front();
				bad = (e.up !== arrow_up) || (e.color !== color_out) || (e.last !== last_of_run);
				for (int j = 0; j < 6; j++) if (e.v[j] !== got[j]) bad = 1;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("triangle mismatch: exp %0d %0d %0d %0d %0d %0d up%0b c%h l%0b",
							e.v[0], e.v[1], e.v[2], e.v[3], e.v[4], e.v[5], e.up, e.color, e.last);
						$display("                   got %0d %0d %0d %0d %0d %0d up%0b c%h l%0b",
							tip_x, tip_y, left_x, left_y, right_x, right_y, arrow_up,
							color_out, last_of_run);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > 3000000) begin
			$display("edge_arrowhead_triangle_builder verification failed");
			$finish;
		end
	end

	task automatic write_scale(logic [15:0] val);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= '0;
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		scale_now = val;
	endtask

	// wait for the phase to drain, then let the sequencer settle
	task automatic drain();
		while (beat_q.size() > 0 || in_valid || tri_q.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		logic [15:0] scales [5];
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, ties, coincident points, no far point, all dir codes
		directed_edge(0, 0, 32767, 32767, 0, 32767, 32767, 0, 12'd4095,
			eatb_pkg::DIR_BOTH, 0);
		directed_edge(500, 500, 500, 500, 500, 500, 500, 500, 12'd256,
			eatb_pkg::DIR_BOTH, 1);
		directed_edge(100, 900, 140, 700, 100, 500, 60, 900, 12'd4095,
			eatb_pkg::DIR_FWD, 0);
		directed_edge(32767, 0, 32000, 10, 31000, 20, 30000, 30, 12'd0,
			eatb_pkg::DIR_BACK, 1);
		directed_edge(200, 200, 201, 201, 202, 202, 203, 203, 12'd2048,
			eatb_pkg::DIR_NONE, 0);
		directed_edge(9000, 100, 8000, 300, 7000, 300, 6000, 9000, 12'd1024,
			eatb_pkg::DIR_FWD, 1);
		drain();

		// overflow corner at full scale, then sweep fixed and random settings
		scales = '{16'hFFFF, 16'd0, 16'd256, 16'($urandom), 16'($urandom_range(1, 4096))};
		for (int ph = 0; ph < 5; ph++) begin
			write_scale(scales[ph]);
			no_idle = (ph == 2);
			if (ph == 0) begin
				directed_edge(32767, 32767, 0, 0, 0, 0, 0, 32767, 12'd4095,
					eatb_pkg::DIR_BOTH, 0);
			end
			while (beat_q.size() < 190) random_edge();
			drain();
		end

		$display("covered %0d beats over %0d edges and 6 pixel scale settings, %0d triangles",
			beats_sent, edges_sent, tris_seen);
		if (mismatches == 0 && tri_q.size() == 0) begin
			$display("edge_arrowhead_triangle_builder verification clean");
		end else begin
			$display("%0d mismatches, %0d triangles missing", mismatches, tri_q.size());
			$display("edge_arrowhead_triangle_builder verification failed");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/eatb_pkg.sv
rtl/core/eatb_mul.sv
rtl/core/eatb_cordic.sv
rtl/core/edge_arrowhead_triangle_builder.sv
test/edge_arrowhead_triangle_builder_tb.sv
